// ----- design/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PL0_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PL0_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PL0_ASSERT(lbl, clk, rst_n, prop, msg)
`define PL0_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- design/pl0sm_pkg.sv -----
`default_nettype none
package pl0sm_pkg;
    localparam int P_BITS = 10;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam logic [3:0] I_LIT = 4'd1;
    localparam logic [3:0] I_OPR = 4'd2;
    localparam logic [3:0] I_LOD = 4'd3;
    localparam logic [3:0] I_STO = 4'd4;
    localparam logic [3:0] I_CAL = 4'd5;
    localparam logic [3:0] I_INC = 4'd6;
    localparam logic [3:0] I_JMP = 4'd7;
    localparam logic [3:0] I_JPC = 4'd8;
    localparam logic [3:0] I_SYS = 4'd9;

    localparam logic [3:0] OPR_RET = 4'd0;
    localparam logic [3:0] OPR_NEG = 4'd1;
    localparam logic [3:0] OPR_ADD = 4'd2;
    localparam logic [3:0] OPR_SUB = 4'd3;
    localparam logic [3:0] OPR_MUL = 4'd4;
    localparam logic [3:0] OPR_DIV = 4'd5;
    localparam logic [3:0] OPR_ODD = 4'd6;
    localparam logic [3:0] OPR_MOD = 4'd7;
    localparam logic [3:0] OPR_EQL = 4'd8;
    localparam logic [3:0] OPR_NEQ = 4'd9;
    localparam logic [3:0] OPR_LSS = 4'd10;
    localparam logic [3:0] OPR_LEQ = 4'd11;
    localparam logic [3:0] OPR_GTR = 4'd12;
    localparam logic [3:0] OPR_GEQ = 4'd13;

    localparam logic [3:0] SYS_WRITE = 4'd1;
    localparam logic [3:0] SYS_READ  = 4'd2;
    localparam logic [3:0] SYS_HALT  = 4'd3;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_HALT = 3'd1;
    localparam logic [2:0] ST_INV  = 3'd2;
    localparam logic [2:0] ST_DIVZ = 3'd3;
    localparam logic [2:0] ST_ADDR = 3'd4;
    localparam logic [2:0] ST_NRUN = 3'd5;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_F1    = 14'b00000000000010,
        S_F2    = 14'b00000000000100,
        S_F3    = 14'b00000000001000,
        S_DEC   = 14'b00000000010000,
        S_LINK  = 14'b00000000100000,
        S_LWAIT = 14'b00000001000000,
        S_RD0   = 14'b00000010000000,
        S_RD1   = 14'b00000100000000,
        S_RD2   = 14'b00001000000000,
        S_EXE   = 14'b00010000000000,
        S_ITER  = 14'b00100000000000,
        S_CMT   = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } t_state;
endpackage
`default_nettype wire

// ----- design/pl0_stack_machine_core.sv -----
// Sequential PL/0 P-machine: a word is accepted while busy is low, and its result is
// strobed on o_valid. Start and rejected words go straight to the result; a load commits
// three words; a step fetches, decodes, walks static links, reads and commits; multiply,
// divide and modulo iterate on the shared adder; results are never stalled. Synchronous
// active-low reset resets state and pointers and stops the program; memory is kept.
`default_nettype none
`include "assert_macros.svh"
module pl0_stack_machine_core
    import pl0sm_pkg::*;
#(
    parameter int MEM_DEPTH = 512,
    parameter int WORD_BITS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_opcode,
    input  wire logic [3:0]         i_instr_op,
    input  wire logic [3:0]         i_instr_level,
    input  wire logic signed [31:0] i_instr_m,
    input  wire logic signed [31:0] i_read_value,
    output logic                    o_valid,
    output logic [P_BITS-1:0]       o_pc_now,
    output logic [P_BITS-1:0]       o_bp_now,
    output logic [P_BITS-1:0]       o_sp_now,
    output logic [P_BITS-1:0]       o_dp_now,
    output logic                    o_write_valid,
    output logic signed [31:0]      o_write_value,
    output logic                    o_read_used,
    output logic [2:0]              o_status
);
    localparam int W  = WORD_BITS;
    localparam int AW = $clog2(MEM_DEPTH);
    localparam int CW = $clog2(WORD_BITS + 1);
    localparam logic [P_BITS-1:0] DEPTH_P = P_BITS'(MEM_DEPTH);

    t_state r_state, n_state;
    logic [P_BITS-1:0] r_pc, n_pc, r_bp, n_bp, r_sp, n_sp, r_dp, n_dp, r_gb, n_gb, r_lc, n_lc;
    logic r_run, n_run;
    logic [P_BITS-1:0] r_xpc, n_xpc, r_xbp, n_xbp, r_xsp, n_xsp, r_xdp, n_xdp;
    logic [W-1:0] r_iop, n_iop, r_m, n_m, r_rv, n_rv, r_a, n_a, r_b, n_b, r_lnk, n_lnk;
    logic [3:0] r_lev, n_lev, r_cnt, n_cnt;
    logic [P_BITS-1:0] r_ra1, n_ra1, r_ra2, n_ra2;
    logic r_two, n_two;
    logic [P_BITS-1:0] r_wa [4];
    logic [P_BITS-1:0] n_wa [4];
    logic [W-1:0] r_wd [4];
    logic [W-1:0] n_wd [4];
    logic [2:0] r_nwr, n_nwr, r_ci, n_ci;
    logic r_halt, n_halt, r_wv, n_wv, r_ru, n_ru;
    logic [2:0] r_stat, n_stat;
    logic [31:0] r_wval, n_wval;
    logic [W-1:0] r_acc, n_acc, r_x, n_x, r_y, n_y;
    logic [CW-1:0] r_it, n_it;
    logic r_isdiv, n_isdiv, r_na, n_na, r_nb, n_nb;

    logic [W-1:0] r_mem [MEM_DEPTH];
    logic [W-1:0] r_rdata;
    logic [P_BITS-1:0] w_ra;
    logic w_we;

    logic flt, w_main, w_lt, w_ge;
    logic [P_BITS-1:0] w_top, w_push, w_pop, w_nb, w_s1, w_s2, w_s3, w_s4;
    logic [63:0] w_m64, w_b64, w_gb64, w_ea, w_in_m64;
    logic w_ea_ok;
    logic [W-1:0] w_opa, w_ma, w_mb;
    logic [W:0] w_sum;
    logic w_io, w_cmt_ok;

    function automatic logic f_ok(input logic [P_BITS-1:0] a);
        f_ok = (a < DEPTH_P);
    endfunction

    function automatic logic f_fits(input logic [W-1:0] v);
        f_fits = ~|v[W-1:P_BITS];
    endfunction

    assign w_main   = (r_xbp == r_gb);
    assign w_top    = w_main ? r_xdp : r_xsp;
    assign w_push   = w_main ? r_xdp + P_BITS'(1) : r_xsp - P_BITS'(1);
    assign w_pop    = w_main ? r_xdp - P_BITS'(1) : r_xsp + P_BITS'(1);
    assign w_nb     = w_main ? w_top - P_BITS'(1) : w_top + P_BITS'(1);
    assign w_s1     = r_xsp - P_BITS'(1);
    assign w_s2     = r_xsp - P_BITS'(2);
    assign w_s3     = r_xsp - P_BITS'(3);
    assign w_s4     = r_xsp - P_BITS'(4);
    assign w_m64    = 64'($signed(r_m));
    assign w_b64    = 64'(r_lnk);
    assign w_gb64   = 64'(r_gb);
    assign w_ea     = (w_b64 == w_gb64) ? w_gb64 + w_m64 : w_b64 - w_m64;
    assign w_ea_ok  = (w_ea < 64'(MEM_DEPTH));
    assign w_in_m64 = 64'(i_instr_m);
    assign w_lt     = ($signed(r_a) < $signed(r_b));
    assign w_ma     = r_a[W-1] ? W'(0) - r_a : r_a;
    assign w_mb     = r_b[W-1] ? W'(0) - r_b : r_b;

    // Shared adder: accumulate for multiply, trial subtract for divide.
    assign w_opa = r_isdiv ? {r_acc[W-2:0], r_y[W-1]} : r_acc;
    assign w_sum = {1'b0, w_opa} + {1'b0, (r_isdiv ? ~r_x : r_x)} + (W+1)'(r_isdiv);
    assign w_ge  = w_sum[W];

    always_comb begin
        n_state = r_state;
        n_pc = r_pc; n_bp = r_bp; n_sp = r_sp; n_dp = r_dp; n_gb = r_gb; n_lc = r_lc;
        n_run = r_run;
        n_xpc = r_xpc; n_xbp = r_xbp; n_xsp = r_xsp; n_xdp = r_xdp;
        n_iop = r_iop; n_m = r_m; n_rv = r_rv; n_a = r_a; n_b = r_b; n_lnk = r_lnk;
        n_lev = r_lev; n_cnt = r_cnt; n_ra1 = r_ra1; n_ra2 = r_ra2; n_two = r_two;
        n_wa = r_wa; n_wd = r_wd; n_nwr = r_nwr; n_ci = r_ci;
        n_halt = r_halt; n_wv = r_wv; n_ru = r_ru; n_stat = r_stat; n_wval = r_wval;
        n_acc = r_acc; n_x = r_x; n_y = r_y; n_it = r_it;
        n_isdiv = r_isdiv; n_na = r_na; n_nb = r_nb;
        flt = 1'b0;
        w_ra = r_ra1;
        case (r_state)
            S_IDLE: begin
                w_ra = r_pc;
                if (start) begin
                    n_xpc = r_pc; n_xbp = r_bp; n_xsp = r_sp; n_xdp = r_dp;
                    n_nwr = 3'd0; n_ci = 3'd0; n_halt = 1'b0; n_stat = ST_OK;
                    n_wv = 1'b0; n_wval = 32'd0; n_ru = 1'b0;
                    n_rv = W'($signed(i_read_value));
                    case (i_opcode)
                        OP_LOAD: begin
                            if (11'(r_lc) + 11'd3 > 11'(MEM_DEPTH)) begin
                                n_stat = ST_ADDR;
                                n_state = S_DONE;
                            end else begin
                                n_wa[0] = r_lc;
                                n_wa[1] = r_lc + P_BITS'(1);
                                n_wa[2] = r_lc + P_BITS'(2);
                                n_wd[0] = W'(i_instr_op);
                                n_wd[1] = W'(i_instr_level);
                                n_wd[2] = w_in_m64[W-1:0];
                                n_nwr = 3'd3;
                                n_lc = r_lc + P_BITS'(3);
                                n_state = S_CMT;
                            end
                        end
                        OP_START: begin
                            n_gb = r_lc; n_bp = r_lc; n_dp = r_lc - P_BITS'(1);
                            n_pc = '0; n_sp = DEPTH_P; n_run = 1'b1;
                            n_state = S_DONE;
                        end
                        OP_STEP: begin
                            if (!r_run) begin
                                n_stat = ST_NRUN;
                                n_state = S_DONE;
                            end else if (11'(r_pc) + 11'd2 >= 11'(MEM_DEPTH)) begin
                                flt = 1'b1;
                            end else begin
                                n_state = S_F1;
                            end
                        end
                        default: begin
                            n_stat = ST_INV;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_F1: begin
                n_iop = r_rdata;
                w_ra = r_xpc + P_BITS'(1);
                n_state = S_F2;
            end
            S_F2: begin
                n_lev = r_rdata[3:0];
                w_ra = r_xpc + P_BITS'(2);
                n_state = S_F3;
            end
            S_F3: begin
                n_m = r_rdata;
                n_xpc = r_xpc + P_BITS'(3);
                n_state = S_DEC;
            end
            S_DEC: begin
                n_state = S_CMT;
                n_two = 1'b0;
                if (r_iop == W'(I_LIT)) begin
                    if (!f_ok(w_push)) flt = 1'b1;
                    n_wa[0] = w_push; n_wd[0] = r_m; n_nwr = 3'd1;
                    if (w_main) n_xdp = w_push; else n_xsp = w_push;
                end else if (r_iop == W'(I_OPR)) begin
                    if (r_m == W'(OPR_RET)) begin
                        n_xsp = r_xbp + P_BITS'(1);
                        n_ra1 = r_xbp - P_BITS'(2);
                        n_ra2 = r_xbp - P_BITS'(3);
                        if (!f_ok(r_xbp - P_BITS'(2)) || !f_ok(r_xbp - P_BITS'(3))) flt = 1'b1;
                        n_two = 1'b1;
                        n_state = S_RD0;
                    end else if (r_m == W'(OPR_NEG) || r_m == W'(OPR_ODD)) begin
                        n_ra1 = w_top;
                        if (!f_ok(w_top)) flt = 1'b1;
                        n_state = S_RD0;
                    end else if (r_m > W'(OPR_GEQ)) begin
                        n_stat = ST_INV;
                    end else begin
                        n_ra1 = w_nb; n_ra2 = w_top;
                        if (!f_ok(w_nb) || !f_ok(w_top)) flt = 1'b1;
                        n_two = 1'b1;
                        n_state = S_RD0;
                    end
                end else if (r_iop == W'(I_LOD) || r_iop == W'(I_STO)
                             || r_iop == W'(I_CAL)) begin
                    n_lnk = W'(r_xbp);
                    n_cnt = (r_iop == W'(I_CAL) || !w_main) ? r_lev : 4'd0;
                    n_state = S_LINK;
                end else if (r_iop == W'(I_INC)) begin
                    if (w_main) n_xdp = r_xdp + r_m[P_BITS-1:0];
                    else n_xsp = r_xsp - r_m[P_BITS-1:0];
                end else if (r_iop == W'(I_JMP)) begin
                    if (!f_fits(r_m)) flt = 1'b1;
                    n_xpc = r_m[P_BITS-1:0];
                end else if (r_iop == W'(I_JPC)) begin
                    n_ra1 = w_top;
                    if (!f_ok(w_top)) flt = 1'b1;
                    n_state = S_RD0;
                end else if (r_iop == W'(I_SYS)) begin
                    if (r_m == W'(SYS_WRITE)) begin
                        n_ra1 = w_top;
                        if (!f_ok(w_top)) flt = 1'b1;
                        n_state = S_RD0;
                    end else if (r_m == W'(SYS_READ)) begin
                        if (!f_ok(w_push)) flt = 1'b1;
                        n_wa[0] = w_push; n_wd[0] = r_rv; n_nwr = 3'd1;
                        if (w_main) n_xdp = w_push; else n_xsp = w_push;
                        n_ru = 1'b1;
                    end else if (r_m == W'(SYS_HALT)) begin
                        n_halt = 1'b1;
                    end else begin
                        n_stat = ST_INV;
                    end
                end else begin
                    n_stat = ST_INV;
                end
            end
            S_LINK: begin
                w_ra = r_lnk[P_BITS-1:0];
                if (r_cnt != 4'd0) begin
                    if (r_lnk >= W'(MEM_DEPTH)) flt = 1'b1;
                    n_state = S_LWAIT;
                end else if (r_iop == W'(I_LOD)) begin
                    if (!w_ea_ok) flt = 1'b1;
                    n_ra1 = w_ea[P_BITS-1:0];
                    n_state = S_RD0;
                end else if (r_iop == W'(I_STO)) begin
                    if (!w_ea_ok || !f_ok(w_top)) flt = 1'b1;
                    n_ra1 = w_top;
                    n_ra2 = w_ea[P_BITS-1:0];
                    n_state = S_RD0;
                end else begin
                    if (!f_ok(w_s1) || !f_ok(w_s2) || !f_ok(w_s3) || !f_ok(w_s4)
                        || !f_fits(r_m)) flt = 1'b1;
                    n_wa[0] = w_s1; n_wd[0] = '0;
                    n_wa[1] = w_s2; n_wd[1] = r_lnk;
                    n_wa[2] = w_s3; n_wd[2] = W'(r_xbp);
                    n_wa[3] = w_s4; n_wd[3] = W'(r_xpc);
                    n_nwr = 3'd4;
                    n_xbp = w_s2;
                    n_xpc = r_m[P_BITS-1:0];
                    n_state = S_CMT;
                end
            end
            S_LWAIT: begin
                n_lnk = r_rdata;
                n_cnt = r_cnt - 4'd1;
                n_state = S_LINK;
            end
            S_RD0: begin
                w_ra = r_ra1;
                n_state = S_RD1;
            end
            S_RD1: begin
                n_a = r_rdata;
                w_ra = r_ra2;
                n_state = r_two ? S_RD2 : S_EXE;
            end
            S_RD2: begin
                n_b = r_rdata;
                n_state = S_EXE;
            end
            S_EXE: begin
                n_state = S_CMT;
                if (r_iop == W'(I_OPR)) begin
                    if (r_m == W'(OPR_RET)) begin
                        if (!f_fits(r_a) || !f_fits(r_b)) flt = 1'b1;
                        n_xbp = r_a[P_BITS-1:0];
                        n_xpc = r_b[P_BITS-1:0];
                    end else if (r_m == W'(OPR_NEG)) begin
                        n_wa[0] = r_ra1; n_wd[0] = W'(0) - r_a; n_nwr = 3'd1;
                    end else if (r_m == W'(OPR_ODD)) begin
                        n_wa[0] = r_ra1; n_wd[0] = W'(r_a[0]); n_nwr = 3'd1;
                    end else begin
                        if (w_main) n_xdp = r_ra1; else n_xsp = r_ra1;
                        n_wa[0] = r_ra1; n_nwr = 3'd1;
                        case (r_m[3:0])
                            OPR_ADD: n_wd[0] = r_a + r_b;
                            OPR_SUB: n_wd[0] = r_a - r_b;
                            OPR_MUL: begin
                                n_acc = '0; n_x = r_a; n_y = r_b; n_it = '0;
                                n_isdiv = 1'b0;
                                n_state = S_ITER;
                            end
                            OPR_DIV, OPR_MOD: begin
                                if (r_b == '0) begin
                                    n_wd[0] = '0;
                                    n_stat = ST_DIVZ;
                                end else begin
                                    n_acc = '0; n_x = w_mb; n_y = w_ma; n_it = '0;
                                    n_isdiv = 1'b1; n_na = r_a[W-1]; n_nb = r_b[W-1];
                                    n_state = S_ITER;
                                end
                            end
                            OPR_EQL: n_wd[0] = W'(r_a == r_b);
                            OPR_NEQ: n_wd[0] = W'(r_a != r_b);
                            OPR_LSS: n_wd[0] = W'(w_lt);
                            OPR_LEQ: n_wd[0] = W'(w_lt || r_a == r_b);
                            OPR_GTR: n_wd[0] = W'(!w_lt && r_a != r_b);
                            default: n_wd[0] = W'(!w_lt);
                        endcase
                    end
                end else if (r_iop == W'(I_LOD)) begin
                    if (!f_ok(w_push)) flt = 1'b1;
                    n_wa[0] = w_push; n_wd[0] = r_a; n_nwr = 3'd1;
                    if (w_main) n_xdp = w_push; else n_xsp = w_push;
                end else if (r_iop == W'(I_STO)) begin
                    if (w_main) n_xdp = w_pop; else n_xsp = w_pop;
                    n_wa[0] = r_ra2; n_wd[0] = r_a; n_nwr = 3'd1;
                end else if (r_iop == W'(I_JPC)) begin
                    if (w_main) n_xdp = w_pop; else n_xsp = w_pop;
                    if (r_a == '0) begin
                        if (!f_fits(r_m)) flt = 1'b1;
                        n_xpc = r_m[P_BITS-1:0];
                    end
                end else begin
                    if (w_main) n_xdp = w_pop; else n_xsp = w_pop;
                    n_wv = 1'b1;
                    n_wval = 32'($signed(r_a));
                end
            end
            S_ITER: begin
                if (r_it != CW'(W)) begin
                    n_it = r_it + CW'(1);
                    if (r_isdiv) begin
                        n_acc = w_ge ? w_sum[W-1:0] : w_opa;
                        n_y = {r_y[W-2:0], w_ge};
                    end else begin
                        n_acc = r_y[0] ? w_sum[W-1:0] : r_acc;
                        n_x = {r_x[W-2:0], 1'b0};
                        n_y = {1'b0, r_y[W-1:1]};
                    end
                end else begin
                    if (!r_isdiv) n_wd[0] = r_acc;
                    else if (r_m[3:0] == OPR_MOD) n_wd[0] = r_na ? W'(0) - r_acc : r_acc;
                    else n_wd[0] = (r_na ^ r_nb) ? W'(0) - r_y : r_y;
                    n_state = S_CMT;
                end
            end
            S_CMT: begin
                if (r_ci != r_nwr) begin
                    n_ci = r_ci + 3'd1;
                end else begin
                    n_pc = r_xpc; n_bp = r_xbp; n_sp = r_xsp; n_dp = r_xdp;
                    if (r_halt) begin
                        n_stat = ST_HALT;
                        n_run = 1'b0;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (flt) begin
            n_state = S_DONE;
            n_stat = ST_ADDR;
            n_run = 1'b0;
            n_wv = 1'b0;
            n_wval = 32'd0;
            n_ru = 1'b0;
        end
    end

    assign w_we = (r_state == S_CMT) && (r_ci != r_nwr);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_wa[r_ci[1:0]][AW-1:0]] <= r_wd[r_ci[1:0]];
        end
        r_rdata <= r_mem[w_ra[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc <= '0; r_bp <= '0; r_sp <= DEPTH_P; r_dp <= '0; r_gb <= '0; r_lc <= '0;
            r_run <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc <= n_pc; r_bp <= n_bp; r_sp <= n_sp; r_dp <= n_dp; r_gb <= n_gb;
            r_lc <= n_lc;
            r_run <= n_run;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xpc <= n_xpc; r_xbp <= n_xbp; r_xsp <= n_xsp; r_xdp <= n_xdp;
        r_iop <= n_iop; r_m <= n_m; r_rv <= n_rv; r_a <= n_a; r_b <= n_b; r_lnk <= n_lnk;
        r_lev <= n_lev; r_cnt <= n_cnt; r_ra1 <= n_ra1; r_ra2 <= n_ra2; r_two <= n_two;
        r_wa <= n_wa; r_wd <= n_wd; r_nwr <= n_nwr; r_ci <= n_ci;
        r_halt <= n_halt; r_wv <= n_wv; r_ru <= n_ru; r_stat <= n_stat; r_wval <= n_wval;
        r_acc <= n_acc; r_x <= n_x; r_y <= n_y; r_it <= n_it;
        r_isdiv <= n_isdiv; r_na <= n_na; r_nb <= n_nb;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_DONE);
    assign o_pc_now      = r_pc;
    assign o_bp_now      = r_bp;
    assign o_sp_now      = r_sp;
    assign o_dp_now      = r_dp;
    assign o_write_valid = r_wv;
    assign o_write_value = r_wval;
    assign o_read_used   = r_ru;
    assign o_status      = r_stat;

    assign w_io     = o_write_valid || o_read_used;
    assign w_cmt_ok = (r_ci <= r_nwr) && (r_nwr <= 3'd4);

    `PL0_ASSERT(a_done_then_idle, i_clk, i_rst_n, o_valid |=> !busy, "result not followed by idle")
    `PL0_ASSERT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "accepted word left idle")
    `PL0_ASSERT(a_io_ok, i_clk, i_rst_n, (o_valid && w_io) |-> (o_status == ST_OK), "bad io status")
    `PL0_ASSERT(a_cmt_bound, i_clk, i_rst_n, (r_state == S_CMT) |-> w_cmt_ok, "write overrun")
endmodule
`default_nettype wire
